[sv/rgb_clamp_histogram_assert.svh]
// assertion macros shared by the rgb clamp histogram modules
`ifndef RGB_CLAMP_HISTOGRAM_ASSERT_SVH
`define RGB_CLAMP_HISTOGRAM_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RGBCH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbch assertion failed");

// next-cycle implication, checked out of reset
`define RGBCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbch assertion failed");

`endif

[sv/rgbch_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbch_pkg
// shared types, constants and helpers of the rgb clamp histogram block
// ---------------------------------------------------------------------------
package rgbch_pkg;

    localparam int PIX_BITS       = 8;
    localparam int NUM_CHAN       = 3;
    localparam int BIN_COUNT      = 256;
    localparam int BIN_BITS       = $clog2(BIN_COUNT);
    localparam int COUNT_BITS     = 24;
    localparam int OUT_COUNT_BITS = 24;
    localparam int OP_BITS        = 2;
    localparam int CFG_IDX_BITS   = 3;

    typedef logic [PIX_BITS-1:0]       pix_t;
    typedef logic [BIN_BITS-1:0]       bin_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [OUT_COUNT_BITS-1:0] out_count_t;
    typedef logic [OP_BITS-1:0]        op_t;
    typedef logic [CFG_IDX_BITS-1:0]   cfg_idx_t;

    localparam count_t COUNT_MAX = '1;

    // item codes
    localparam op_t OP_PIXEL = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    // register indexes
    localparam cfg_idx_t REG_RED_MIN   = 3'd0;
    localparam cfg_idx_t REG_RED_MAX   = 3'd1;
    localparam cfg_idx_t REG_GREEN_MIN = 3'd2;
    localparam cfg_idx_t REG_GREEN_MAX = 3'd3;
    localparam cfg_idx_t REG_BLUE_MIN  = 3'd4;
    localparam cfg_idx_t REG_BLUE_MAX  = 3'd5;

    localparam int CHAN_RED   = 0;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE  = 2;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch the input word
        logic update;   // bump the bins of a pixel word and load the output register
        logic clear;    // write zero at the sweep address and step it
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register empty or being taken
        logic clear_op;   // latched word is a clear
        logic clear_last; // sweep is at the last bin
    } ctrl_sts_t;

    // minimum test wins when the bounds cross
    function automatic pix_t clamp_pix(pix_t v, pix_t lo, pix_t hi);
        pix_t r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // low bits of a count, zero extended when the count is narrower
    function automatic out_count_t fit_count(count_t c);
        return OUT_COUNT_BITS'({{OUT_COUNT_BITS{1'b0}}, c});
    endfunction

endpackage

[sv/rgb_clamp_histogram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_clamp_histogram
// per-channel rgb clamp with three saturating 256-bin histograms
// ---------------------------------------------------------------------------
// input channel (in_valid / in_stall) carries one word: op, red_in, green_in,
//   blue_in, bin_index. op pixel clamps and bins the pixel, op read returns
//   the three counts of bin_index, op clear empties all bins, op 3 does nothing
// output channel (out_valid / out_stall) returns exactly one word per input
//   word: clamped pixel for pixel words, counts for read words, zeros otherwise
// config channel (cfg_valid / cfg_ready) writes the six clamp bounds by
//   index; cfg_ready is always high, indexes above five are dropped
// result: registered after the ram read once the output register is free;
//   a new word is taken only after accept, ram read, then ram write of the
//   bumped counts (pixel words only) of the word before
// clear: after its result is loaded, zeros sweep through the 256 bins one per
//   cycle, and the next word is taken only once the sweep has ended
// reset: bounds go to 0 / 255 and the same sweep of all 256 bins runs with in_stall high
// output stall: the finished word waits in the output register; the next
//   word may be accepted and is held before its ram update until taken
// ---------------------------------------------------------------------------
module rgb_clamp_histogram (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  rgbch_pkg::op_t         op,
    input  rgbch_pkg::pix_t        red_in,
    input  rgbch_pkg::pix_t        green_in,
    input  rgbch_pkg::pix_t        blue_in,
    input  rgbch_pkg::bin_t        bin_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rgbch_pkg::pix_t        red_out,
    output rgbch_pkg::pix_t        green_out,
    output rgbch_pkg::pix_t        blue_out,
    output rgbch_pkg::out_count_t  red_count,
    output rgbch_pkg::out_count_t  green_count,
    output rgbch_pkg::out_count_t  blue_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  rgbch_pkg::cfg_idx_t    cfg_index,
    input  rgbch_pkg::pix_t        cfg_data
);

    rgbch_pkg::ctrl_cmd_t cmd;
    rgbch_pkg::ctrl_sts_t sts;

    // bounds are plain registers, a write can land on any cycle
    assign cfg_ready = 1'b1;

    // sequencer: idle, histogram read, update, bin sweep
    rgbch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // clamp, histogram rams with clearing sweep, result register
    rgbch_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .bin_index   (bin_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .red_count   (red_count),
        .green_count (green_count),
        .blue_count  (blue_count)
    );

endmodule

[sv/rgbch_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbch_ram
// single port ram with registered read data
// ---------------------------------------------------------------------------
module rgbch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/rgbch_ctrl.sv]
`timescale 1ns / 1ps
`include "rgb_clamp_histogram_assert.svh"
// ---------------------------------------------------------------------------
// rgbch_ctrl
// item sequencer: accept, histogram read, update, bin sweep and result load
// ---------------------------------------------------------------------------
module rgbch_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rgbch_pkg::ctrl_sts_t  sts,
    output rgbch_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_CLEAR  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_READ;
            end
            S_READ:
            begin
                // hold the read until the result slot is free
                if (sts.out_free)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // a clear word goes on to sweep the bins
                if (sts.clear_op)
                    state_next = S_CLEAR;
                else
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // reset starts with a sweep so every bin reads zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.accept = (state_reg == S_IDLE) && in_valid;
    assign cmd.update = (state_reg == S_UPDATE);
    assign cmd.clear  = (state_reg == S_CLEAR);

    `RGBCH_ASSERT_NEXT(a_accept_then_read, cmd.accept, state_reg == S_READ)
    `RGBCH_ASSERT_NEXT(a_read_waits, (state_reg == S_READ) && !sts.out_free,
        state_reg == S_READ)
    `RGBCH_ASSERT_NEXT(a_update_once, cmd.update, !cmd.update)
    `RGBCH_ASSERT_SAME(a_clear_stalls, cmd.clear, in_stall && !cmd.accept)

endmodule

[sv/rgbch_dpath.sv]
`timescale 1ns / 1ps
`include "rgb_clamp_histogram_assert.svh"
// ---------------------------------------------------------------------------
// rgbch_dpath
// bounds registers, clamp, three histogram rams and result register
// ---------------------------------------------------------------------------
module rgbch_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rgbch_pkg::ctrl_cmd_t        cmd,
    output rgbch_pkg::ctrl_sts_t        sts,
    input  rgbch_pkg::op_t              op,
    input  rgbch_pkg::pix_t             red_in,
    input  rgbch_pkg::pix_t             green_in,
    input  rgbch_pkg::pix_t             blue_in,
    input  rgbch_pkg::bin_t             bin_index,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  rgbch_pkg::cfg_idx_t         cfg_index,
    input  rgbch_pkg::pix_t             cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output rgbch_pkg::pix_t             red_out,
    output rgbch_pkg::pix_t             green_out,
    output rgbch_pkg::pix_t             blue_out,
    output rgbch_pkg::out_count_t       red_count,
    output rgbch_pkg::out_count_t       green_count,
    output rgbch_pkg::out_count_t       blue_count
);

    rgbch_pkg::pix_t    min_reg [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::pix_t    max_reg [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::op_t     op_reg;
    rgbch_pkg::bin_t    addr_reg [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::bin_t    clr_addr_reg;

    rgbch_pkg::pix_t    pix_in    [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::count_t  rdata     [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::count_t  cnt_cur   [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::count_t  cnt_inc   [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::bin_t    ram_addr  [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::count_t  ram_wdata [rgbch_pkg::NUM_CHAN];
    logic               bump_we;
    logic               ram_we;

    logic                   out_valid_reg;
    rgbch_pkg::pix_t        pix_out_reg [rgbch_pkg::NUM_CHAN];
    rgbch_pkg::out_count_t  cnt_out_reg [rgbch_pkg::NUM_CHAN];

    assign pix_in[rgbch_pkg::CHAN_RED]   = red_in;
    assign pix_in[rgbch_pkg::CHAN_GREEN] = green_in;
    assign pix_in[rgbch_pkg::CHAN_BLUE]  = blue_in;

    // bounds registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < rgbch_pkg::NUM_CHAN; c++)
            begin
                min_reg[c] <= '0;
                max_reg[c] <= '1;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rgbch_pkg::REG_RED_MIN:   min_reg[rgbch_pkg::CHAN_RED]   <= cfg_data;
                rgbch_pkg::REG_RED_MAX:   max_reg[rgbch_pkg::CHAN_RED]   <= cfg_data;
                rgbch_pkg::REG_GREEN_MIN: min_reg[rgbch_pkg::CHAN_GREEN] <= cfg_data;
                rgbch_pkg::REG_GREEN_MAX: max_reg[rgbch_pkg::CHAN_GREEN] <= cfg_data;
                rgbch_pkg::REG_BLUE_MIN:  min_reg[rgbch_pkg::CHAN_BLUE]  <= cfg_data;
                rgbch_pkg::REG_BLUE_MAX:  max_reg[rgbch_pkg::CHAN_BLUE]  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // latched word: bin address is the clamped value or the requested bin
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= op;
            for (int c = 0; c < rgbch_pkg::NUM_CHAN; c++)
            begin
                if (op == rgbch_pkg::OP_PIXEL)
                    addr_reg[c] <= rgbch_pkg::clamp_pix(pix_in[c], min_reg[c], max_reg[c]);
                else
                    addr_reg[c] <= bin_index;
            end
        end
    end

    // clearing sweep address, one bin per cycle, wraps back to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    assign bump_we = cmd.update && (op_reg == rgbch_pkg::OP_PIXEL);
    assign ram_we  = bump_we || cmd.clear;

    // saturating bump, or zeros while sweeping
    always_comb
    begin
        for (int c = 0; c < rgbch_pkg::NUM_CHAN; c++)
        begin
            cnt_cur[c]   = rdata[c];
            cnt_inc[c]   = (cnt_cur[c] == rgbch_pkg::COUNT_MAX) ? cnt_cur[c]
                                                                : cnt_cur[c] + 1'b1;
            ram_addr[c]  = cmd.clear ? clr_addr_reg : addr_reg[c];
            ram_wdata[c] = cmd.clear ? '0 : cnt_inc[c];
        end
    end

    for (genvar g = 0; g < rgbch_pkg::NUM_CHAN; g++)
    begin : g_hist
        rgbch_ram #(
            .WIDTH (rgbch_pkg::COUNT_BITS),
            .DEPTH (rgbch_pkg::BIN_COUNT)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .addr  (ram_addr[g]),
            .wdata (ram_wdata[g]),
            .rdata (rdata[g])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.update)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            for (int c = 0; c < rgbch_pkg::NUM_CHAN; c++)
            begin
                pix_out_reg[c] <= (op_reg == rgbch_pkg::OP_PIXEL) ? addr_reg[c] : '0;
                cnt_out_reg[c] <= (op_reg == rgbch_pkg::OP_READ)
                                  ? rgbch_pkg::fit_count(cnt_cur[c]) : '0;
            end
        end
    end

    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.clear_op   = (op_reg == rgbch_pkg::OP_CLEAR);
    assign sts.clear_last = (clr_addr_reg == rgbch_pkg::bin_t'(rgbch_pkg::BIN_COUNT - 1));

    assign out_valid   = out_valid_reg;
    assign red_out     = pix_out_reg[rgbch_pkg::CHAN_RED];
    assign green_out   = pix_out_reg[rgbch_pkg::CHAN_GREEN];
    assign blue_out    = pix_out_reg[rgbch_pkg::CHAN_BLUE];
    assign red_count   = cnt_out_reg[rgbch_pkg::CHAN_RED];
    assign green_count = cnt_out_reg[rgbch_pkg::CHAN_GREEN];
    assign blue_count  = cnt_out_reg[rgbch_pkg::CHAN_BLUE];

    `RGBCH_ASSERT_SAME(a_no_overwrite, cmd.update, !out_valid_reg)
    `RGBCH_ASSERT_NEXT(a_sweep_step, cmd.clear,
        clr_addr_reg == $past(clr_addr_reg) + 1'b1)
    `RGBCH_ASSERT_SAME(a_sweep_from_zero, cmd.update && sts.clear_op, clr_addr_reg == '0)

endmodule
